@@ rtl/ppes_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppes_pkg
// Shared types and codes for the priority / EDF scheduler.
// ----------------------------------------------------------------------------
package ppes_pkg;

    localparam logic [1:0] PH_NEW   = 2'd0;
    localparam logic [1:0] PH_READY = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef struct packed {
        logic [9:0]  ident;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [15:0] deadline;
    } load_t;

    // candidate handed down the chain during a scan
    typedef struct packed {
        logic        found;
        logic [9:0]  ident;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [15:0] deadline;
        logic [15:0] remaining;
        logic        started;
    } cand_t;

    typedef struct packed {
        logic load;
        logic admit;
        logic run;
        logic run_done;
        logic policy;
        logic active;
    } cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/ppes_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppes_cell
// One task entry plus one stage of the selection chain.
// ----------------------------------------------------------------------------
module ppes_cell
    import ppes_pkg::*;
#(
    parameter int TIME_BITS = 20,
    parameter int IDX_BITS  = 4,
    parameter int MY_IDX    = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cell_ctl_t            ctl,
    input  wire load_t                load_data,
    input  wire logic [TIME_BITS-1:0] now_time,
    input  wire cand_t                cand_in,
    input  wire logic [IDX_BITS-1:0]  slot_in,
    input  wire logic [TIME_BITS-1:0] fr_in,
    output cand_t                     cand_out,
    output logic [IDX_BITS-1:0]       slot_out,
    output logic [TIME_BITS-1:0]      fr_out,
    output logic                      finished
);

    load_t                e_reg;
    logic [15:0]          rem_reg;
    logic [TIME_BITS-1:0] fr_reg;
    logic [1:0]           phase_reg;
    logic                 started_reg;

    cand_t                cand_reg, cand_next;
    logic [IDX_BITS-1:0]  slot_reg, slot_next;
    logic [TIME_BITS-1:0] frc_reg, frc_next;

    logic [15:0] key_self, key_in;
    logic        wins;

    always_comb begin
        key_self = ctl.policy ? e_reg.deadline : {8'd0, e_reg.prio};
        key_in   = ctl.policy ? cand_in.deadline : {8'd0, cand_in.prio};
        if (!cand_in.found) begin
            wins = 1'b1;
        end else if (key_self != key_in) begin
            wins = key_self < key_in;
        end else if (e_reg.arrival != cand_in.arrival) begin
            wins = e_reg.arrival < cand_in.arrival;
        end else begin
            wins = e_reg.ident < cand_in.ident;
        end
        if (ctl.active && phase_reg == PH_READY && wins) begin
            cand_next.found     = 1'b1;
            cand_next.ident     = e_reg.ident;
            cand_next.arrival   = e_reg.arrival;
            cand_next.burst     = e_reg.burst;
            cand_next.prio      = e_reg.prio;
            cand_next.deadline  = e_reg.deadline;
            cand_next.remaining = rem_reg;
            cand_next.started   = started_reg;
            slot_next           = IDX_BITS'(MY_IDX);
            frc_next            = fr_reg;
        end else begin
            cand_next = cand_in;
            slot_next = slot_in;
            frc_next  = fr_in;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
        slot_reg <= slot_next;
        frc_reg  <= frc_next;
        if (ctl.load) begin
            e_reg   <= load_data;
            rem_reg <= load_data.burst;
        end else if (ctl.run) begin
            if (!started_reg) begin
                fr_reg <= now_time;
            end
            if (rem_reg != 16'd0) begin
                rem_reg <= rem_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_NEW;
            started_reg <= 1'b0;
        end else if (ctl.load) begin
            phase_reg   <= PH_NEW;
            started_reg <= 1'b0;
        end else if (ctl.admit) begin
            if (ctl.active && phase_reg == PH_NEW &&
                TIME_BITS'(e_reg.arrival) <= now_time) begin
                phase_reg <= PH_READY;
            end
        end else if (ctl.run) begin
            started_reg <= 1'b1;
            if (ctl.run_done) begin
                phase_reg <= PH_DONE;
            end
        end
    end

    assign cand_out = cand_reg;
    assign slot_out = slot_reg;
    assign fr_out   = frc_reg;
    assign finished = (phase_reg == PH_DONE);

endmodule
`default_nettype wire

@@ rtl/preemptive_priority_edf_scheduler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// preemptive_priority_edf_scheduler
// Preemptive task-cell scheduler: one time unit per tick until all tasks finish.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: tuser = cmd (0 load an entry, 1 one time tick). tdata carries the
//   entry fields for a load; ignored for a tick.
//   m_axis: exactly one result item per input item (tick report or load ack).
//   cfg: index 0 = policy (0 priority, 1 EDF), index 1 = task_count.
//   Write config only when idle.
// Sequence:
//   A load goes from its accept cycle straight to the result cycle. A tick
//   runs the accept cycle, an admit cycle, the scan in which the candidate
//   ripples down the cell chain, an execute cycle and the result cycle. A
//   tick that finds every task finished skips admit, scan and execute and
//   leaves time as it is. One item is in work at a time.
// Reset (aresetn low, synchronous): time 0, all entries new, policy 0,
//   task_count 0, no result pending.
// Stall: the result sits in the output register; the next item is accepted
//   and worked, and waits at its result cycle until the register is free.
// ----------------------------------------------------------------------------
module preemptive_priority_edf_scheduler
    import ppes_pkg::*;
#(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 20
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [3:0] slot, [13:4] task_id, [29:14] arrival, [45:30] burst,
    // [53:46] prio, [69:54] deadline, [71:70] zero
    input  wire logic [71:0]  s_axis_tdata,
    // [0] cmd
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [19:0] time_now, [20] idle, [30:21] run_id, [31] switched,
    // [32] done_valid, [52:33] done_time, [72:53] turnaround,
    // [92:73] waiting, [112:93] response, [113] deadline_miss,
    // [114] all_done, [119:115] zero
    output logic [119:0]      m_axis_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [4:0]   cfg_data
);

    localparam int IDX_BITS = $clog2(MAX_TASKS);
    localparam int CNT_BITS = $clog2(MAX_TASKS + 1);
    localparam int CMP_BITS = (CNT_BITS > 5) ? CNT_BITS : 5;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [10:0] IDLE_MARK = 11'd1024;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADMIT = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]           state_reg;
    logic [CNT_BITS-1:0]  scan_reg;
    logic                 policy_reg;
    logic [4:0]           count_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [10:0]          last_reg;

    // pending result (all_done is added at the result cycle)
    logic [19:0] p_time_reg;
    logic        p_idle_reg, p_sw_reg, p_done_reg, p_miss_reg;
    logic [9:0]  p_id_reg;
    logic [19:0] p_fin_reg, p_tat_reg, p_wt_reg, p_rsp_reg;
    logic [119:0] out_reg;
    logic         out_valid_reg;

    load_t                ld;
    logic                 s_fire;
    logic [4:0]           slot_in;
    cell_ctl_t            ctl    [MAX_TASKS];
    cand_t                cand_c [MAX_TASKS+1];
    logic [IDX_BITS-1:0]  slot_c [MAX_TASKS+1];
    logic [TIME_BITS-1:0] fr_c   [MAX_TASKS+1];
    logic [MAX_TASKS-1:0] fin_vec, act_vec;
    logic                 all_done;

    cand_t                win;
    logic [IDX_BITS-1:0]  win_slot;
    logic [TIME_BITS-1:0] t_next, t_arr, t_bur, t_fr, t_tat, t_wt, t_rsp;
    logic                 win_done, out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign ld.ident    = s_axis_tdata[13:4];
    assign ld.arrival  = s_axis_tdata[29:14];
    assign ld.burst    = s_axis_tdata[45:30];
    assign ld.prio     = s_axis_tdata[53:46];
    assign ld.deadline = s_axis_tdata[69:54];
    assign slot_in     = {1'b0, s_axis_tdata[3:0]};

    // head of the chain: no candidate yet
    assign cand_c[0] = '0;
    assign slot_c[0] = '0;
    assign fr_c[0]   = '0;

    assign win      = cand_c[MAX_TASKS];
    assign win_slot = slot_c[MAX_TASKS];

    // finish figures of the chosen task
    always_comb begin
        t_next   = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + 1'b1;
        t_arr    = TIME_BITS'(win.arrival);
        t_bur    = TIME_BITS'(win.burst);
        t_fr     = win.started ? fr_c[MAX_TASKS] : time_reg;
        t_tat    = (t_next >= t_arr) ? t_next - t_arr : '0;
        t_wt     = (t_tat >= t_bur) ? t_tat - t_bur : '0;
        t_rsp    = (t_fr >= t_arr) ? t_fr - t_arr : '0;
        win_done = (win.remaining <= 16'd1);
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
            always_comb begin
                ctl[gi].policy   = policy_reg;
                ctl[gi].active   = CMP_BITS'(gi) < CMP_BITS'(count_reg);
                ctl[gi].load     = s_fire && s_axis_tuser == CMD_LOAD &&
                                   slot_in == 5'(gi);
                ctl[gi].admit    = (state_reg == ST_ADMIT);
                ctl[gi].run      = (state_reg == ST_EXEC) && win.found &&
                                   win_slot == IDX_BITS'(gi);
                ctl[gi].run_done = win_done;
            end
            assign act_vec[gi] = ctl[gi].active;

            ppes_cell #(
                .TIME_BITS (TIME_BITS),
                .IDX_BITS  (IDX_BITS),
                .MY_IDX    (gi)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl[gi]),
                .load_data (ld),
                .now_time  (time_reg),
                .cand_in   (cand_c[gi]),
                .slot_in   (slot_c[gi]),
                .fr_in     (fr_c[gi]),
                .cand_out  (cand_c[gi+1]),
                .slot_out  (slot_c[gi+1]),
                .fr_out    (fr_c[gi+1]),
                .finished  (fin_vec[gi])
            );
        end
    endgenerate

    assign all_done = &(fin_vec | ~act_vec);

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= 1'b0;
            count_reg  <= 5'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_POLICY: policy_reg <= cfg_data[0];
                REG_COUNT:  count_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // control sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            time_reg      <= '0;
            last_reg      <= IDLE_MARK;
            out_valid_reg <= 1'b0;
        end else begin
            // a new result replaces the one leaving in the same cycle
            if (state_reg == ST_FIN && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_axis_tuser == CMD_TICK && !all_done) begin
                            state_reg <= ST_ADMIT;
                        end else begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_ADMIT: begin
                    scan_reg  <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == CNT_BITS'(MAX_TASKS - 1)) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    time_reg  <= t_next;
                    last_reg  <= win.found ? {1'b0, win.ident} : IDLE_MARK;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_fire) begin
            p_time_reg <= 20'(time_reg);
            p_idle_reg <= 1'b1;
            p_id_reg   <= '0;
            p_sw_reg   <= 1'b0;
            p_done_reg <= 1'b0;
            p_fin_reg  <= '0;
            p_tat_reg  <= '0;
            p_wt_reg   <= '0;
            p_rsp_reg  <= '0;
            p_miss_reg <= 1'b0;
        end
        if (state_reg == ST_EXEC && win.found) begin
            p_idle_reg <= 1'b0;
            p_id_reg   <= win.ident;
            p_sw_reg   <= last_reg != {1'b0, win.ident};
            if (win_done) begin
                p_done_reg <= 1'b1;
                p_fin_reg  <= 20'(t_next);
                p_tat_reg  <= 20'(t_tat);
                p_wt_reg   <= 20'(t_wt);
                p_rsp_reg  <= 20'(t_rsp);
                p_miss_reg <= t_next > TIME_BITS'(win.deadline);
            end
        end
        if (state_reg == ST_FIN && out_free) begin
            out_reg <= {5'd0, all_done, p_miss_reg, p_rsp_reg, p_wt_reg,
                        p_tat_reg, p_fin_reg, p_done_reg, p_sw_reg, p_id_reg,
                        p_idle_reg, p_time_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule
`default_nettype wire

@@ sim/tb_preemptive_priority_edf_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_preemptive_priority_edf_scheduler
// Self-checking bench for the priority / EDF scheduler. Loads task tables,
// ticks time under both policies and several task counts, and compares every
// result item field by field against an in-bench scheduler model. Both stream
// sides idle at random; one long output hold fills the block and stalls it.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_edf_scheduler;
    import ppes_pkg::*;

    localparam int  N_SLOTS     = 16;
    localparam int  IDLE_RUNNER = 1024;
    localparam int  DRAIN_WAIT  = 40;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  ITEM_GOAL   = 750;
    localparam int  HOLD_LEN    = 400;
    localparam logic POL_PRIO   = 1'b0;
    localparam logic POL_EDF    = 1'b1;
    localparam logic [19:0] TIME_TOP = 20'hFFFFF;

    // lowest field first in the bus, so it is declared last here
    typedef struct packed {
        logic        all_done;
        logic        deadline_miss;
        logic [19:0] response;
        logic [19:0] waiting;
        logic [19:0] turnaround;
        logic [19:0] done_time;
        logic        done_valid;
        logic        switched;
        logic [9:0]  run_id;
        logic        idle;
        logic [19:0] time_now;
    } tick_report_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    wire           s_axis_tready;
    logic [71:0]   s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0;
    wire           m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    wire  [119:0]  m_axis_tdata;
    logic          cfg_valid = 1'b0;
    wire           cfg_ready;
    logic          cfg_index = 1'b0;
    logic [4:0]    cfg_data = '0;

    preemptive_priority_edf_scheduler dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 aclk = ~aclk;

    // ---------------- scheduler model state ----------------
    load_t       tbl [N_SLOTS];
    logic [15:0] left_units [N_SLOTS];
    logic [19:0] first_run [N_SLOTS];
    logic [1:0]  phase [N_SLOTS];
    logic        started [N_SLOTS];
    logic [19:0] clock_now = '0;
    int          prev_runner = IDLE_RUNNER;
    logic        cur_policy = POL_PRIO;
    logic [4:0]  cur_count = '0;

    tick_report_t report_q[$];
    int  items_sent = 0;
    int  mismatches = 0;
    int  cycles = 0;
    bit  steady_send = 0;      // when set the sender never pauses
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  rx_roll;

    function automatic int counted();
        return (cur_count > N_SLOTS) ? N_SLOTS : int'(cur_count);
    endfunction

    function automatic bit everyone_done();
        int i;
        for (i = 0; i < counted(); i++)
            if (phase[i] != PH_DONE) return 1'b0;
        return 1'b1;
    endfunction

    // a beats b: key, then arrival, then id; equal keeps the lower slot
    function automatic bit outranks(int a, int b);
        int ka, kb;
        ka = (cur_policy == POL_EDF) ? int'(tbl[a].deadline) : int'(tbl[a].prio);
        kb = (cur_policy == POL_EDF) ? int'(tbl[b].deadline) : int'(tbl[b].prio);
        if (ka != kb) return ka < kb;
        if (tbl[a].arrival != tbl[b].arrival) return tbl[a].arrival < tbl[b].arrival;
        return tbl[a].ident < tbl[b].ident;
    endfunction

    function automatic tick_report_t schedule_step(logic cmd, logic [3:0] slot, load_t ld);
        tick_report_t r;
        int i, best;
        int unsigned nxt, arr, bur, tat, wt, fr;
        r = '0;
        r.time_now = clock_now;
        r.idle = 1'b1;
        if (cmd == CMD_LOAD) begin
            tbl[slot] = ld;
            left_units[slot] = ld.burst;
            first_run[slot] = '0;
            phase[slot] = PH_NEW;
            started[slot] = 1'b0;
            r.all_done = everyone_done();
            return r;
        end
        if (everyone_done()) begin
            r.all_done = 1'b1;
            return r;
        end
        for (i = 0; i < counted(); i++)
            if (phase[i] == PH_NEW && 20'(tbl[i].arrival) <= clock_now) phase[i] = PH_READY;
        best = -1;
        for (i = 0; i < counted(); i++)
            if (phase[i] == PH_READY && (best < 0 || outranks(i, best))) best = i;
        nxt = (clock_now != TIME_TOP) ? 32'(clock_now) + 32'd1 : 32'(clock_now);
        if (best < 0) begin
            prev_runner = IDLE_RUNNER;
        end else begin
            r.idle = 1'b0;
            r.run_id = tbl[best].ident;
            r.switched = (prev_runner != int'(tbl[best].ident));
            prev_runner = int'(tbl[best].ident);
            if (!started[best]) begin
                started[best] = 1'b1;
                first_run[best] = clock_now;
            end
            if (left_units[best] != 0) left_units[best]--;
            if (left_units[best] == 0) begin
                // zero burst lands here too: done after one unit
                arr = 32'(tbl[best].arrival);
                bur = 32'(tbl[best].burst);
                fr  = 32'(first_run[best]);
                tat = (nxt >= arr) ? nxt - arr : 32'd0;
                wt  = (tat >= bur) ? tat - bur : 32'd0;
                phase[best] = PH_DONE;
                r.done_valid = 1'b1;
                r.done_time = 20'(nxt);
                r.turnaround = 20'(tat);
                r.waiting = 20'(wt);
                r.response = (fr >= arr) ? 20'(fr - arr) : 20'd0;
                r.deadline_miss = nxt > 32'(tbl[best].deadline);
            end
        end
        clock_now = 20'(nxt);
        r.all_done = everyone_done();
        return r;
    endfunction

    // ---------------- output side ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70) begin
                m_axis_tready <= 1'b1;
            end else if (rx_roll < 95) begin
                m_axis_tready <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end else begin
                m_axis_tready <= 1'b0;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    task automatic check_field(string name, logic [19:0] want, logic [19:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        tick_report_t want, got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[114:0];
            if (report_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item, expected none, actual %h", $realtime, got);
            end else begin
                want = report_q.pop_front();
                check_field("time_now", want.time_now, got.time_now);
                check_field("idle", 20'(want.idle), 20'(got.idle));
                check_field("run_id", 20'(want.run_id), 20'(got.run_id));
                check_field("switched", 20'(want.switched), 20'(got.switched));
                check_field("done_valid", 20'(want.done_valid), 20'(got.done_valid));
                check_field("done_time", want.done_time, got.done_time);
                check_field("turnaround", want.turnaround, got.turnaround);
                check_field("waiting", want.waiting, got.waiting);
                check_field("response", want.response, got.response);
                check_field("deadline_miss", 20'(want.deadline_miss),
                            20'(got.deadline_miss));
                check_field("all_done", 20'(want.all_done), 20'(got.all_done));
            end
        end
    end

    // ---------------- input side ----------------
    function automatic int pick_gap();
        int r;
        if (steady_send) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(logic cmd, logic [3:0] slot, load_t ld);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {2'b00, ld.deadline, ld.prio, ld.burst, ld.arrival, ld.ident, slot};
        do @(posedge aclk); while (!s_axis_tready);
        report_q.push_back(schedule_step(cmd, slot, ld));
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic load_t rand_fields();
        load_t ld;
        ld.ident = 10'($urandom);
        ld.arrival = 16'($urandom);
        ld.burst = 16'($urandom);
        ld.prio = 8'($urandom);
        ld.deadline = 16'($urandom);
        return ld;
    endfunction

    // mostly runnable tasks near the current time; sometimes any field values
    function automatic load_t make_task();
        load_t ld;
        ld = rand_fields();
        if ($urandom_range(0, 9) == 0) return ld;
        ld.ident = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 3)) : 10'($urandom);
        ld.arrival = 16'(clock_now[15:0] + $urandom_range(0, 8));
        ld.burst = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        ld.prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        ld.deadline = 16'(clock_now[15:0] + $urandom_range(0, 40));
        return ld;
    endfunction

    task automatic tick();
        send_item(CMD_TICK, 4'($urandom), rand_fields());
    endtask

    // wait for every result, then for the block to go quiet
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_POLICY) cur_policy = val[0];
        else cur_count = val;
    endtask

    // ---------------- tests ----------------
    // empty run: task_count 0 means all done, ticks stay idle
    task automatic test_empty_run();
        tick();
        tick();
        drain();
        write_reg(REG_COUNT, 5'd31);    // above the table size, acts as 16
    endtask

    // hand-made table: field extremes, ties on every key, never-arriving task
    task automatic test_directed_table();
        load_t ld;
        int i;
        for (i = 0; i < N_SLOTS; i++) begin
            ld.ident = (i == 0) ? 10'd0 : (i == 1) ? 10'd1023 : 10'(i * 37);
            ld.arrival = (i == 2) ? 16'hFFFF : 16'(i % 3);
            ld.burst = (i == 3) ? 16'd0 : 16'((i % 4) + 1);
            ld.prio = (i == 4) ? 8'd255 : (i == 5) ? 8'd0 : 8'(i % 2);
            ld.deadline = (i == 6) ? 16'hFFFF : (i == 7) ? 16'd0 : 16'(20 - i % 3);
            if (i == 11) ld = tbl[10];  // identical entries: lower slot wins
            if (i == 12) ld.burst = 16'hFFFF;
            send_item(CMD_LOAD, 4'(i), ld);
        end
        repeat (4) tick();
        drain();
        write_reg(REG_POLICY, POL_EDF);
        repeat (4) tick();
        drain();
    endtask

    // fresh table under one setting, then the number of items given by ticks, loads mixed in
    task automatic run_phase(logic pol, logic [4:0] cnt, int ticks);
        int i;
        write_reg(REG_POLICY, pol);
        write_reg(REG_COUNT, cnt);
        for (i = 0; i < N_SLOTS; i++)
            if (i < counted() || $urandom_range(0, 3) == 0)
                send_item(CMD_LOAD, 4'(i), make_task());
        for (i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 11) == 0) send_item(CMD_LOAD, 4'($urandom), make_task());
            else tick();
        end
        drain();
    endtask

    task automatic test_setting_sweep();
        run_phase(POL_PRIO, 5'd1, 10);
        run_phase(POL_EDF, 5'd2, 14);
        run_phase(POL_PRIO, 5'd16, 40);
        run_phase(POL_EDF, 5'd16, 40);
        run_phase(POL_PRIO, 5'd0, 4);
    endtask

    // output held for a long stretch while input keeps coming
    task automatic test_backpressure();
        steady_send = 1;
        hold_req++;
        repeat (30) tick();
        steady_send = 0;
        drain();
    endtask

    task automatic test_random_runs();
        logic [4:0] cnt;
        while (items_sent < ITEM_GOAL) begin
            steady_send = ($urandom_range(0, 3) == 0);
            cnt = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                              : 5'($urandom_range(0, 16));
            run_phase(1'($urandom), cnt, $urandom_range(10, 50));
        end
        steady_send = 0;
    endtask

    initial begin
        int i;
        for (i = 0; i < N_SLOTS; i++) begin
            tbl[i] = '0;
            left_units[i] = '0;
            first_run[i] = '0;
            phase[i] = PH_NEW;
            started[i] = 1'b0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_run();
        test_directed_table();
        test_setting_sweep();
        test_backpressure();
        test_random_runs();
        drain();
        if (mismatches == 0 && report_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
